[src/ip_text_address_parser_top_assert.svh]
// Assertion macros for the text address parser.
`ifndef IP_TEXT_ADDRESS_PARSER_TOP_ASSERT_SVH
`define IP_TEXT_ADDRESS_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define IPTA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ipta: assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define IPTA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ipta: assertion failed");

`endif

[src/ipta_pkg.sv]
// Shared types and constants of the text address parser.
`default_nettype none
package ipta_pkg;

    localparam int ZONE_BITS = 8;
    localparam int ZONE_SAT  = (ZONE_BITS >= 8) ? 255 : ((1 << ZONE_BITS) - 1);

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_F_UP  = 8'h46;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_F_LO  = 8'h66;

    typedef enum logic [3:0] {
        ZM_NONE   = 4'b0001,
        ZM_SKIP   = 4'b0010,
        ZM_DIGITS = 4'b0100,
        ZM_DONE   = 4'b1000
    } t_zmode;

    typedef enum logic [2:0] {
        PC_NONE = 3'b001,
        PC_ONE  = 3'b010,
        PC_GAP  = 3'b100
    } t_pend;

    typedef struct packed {
        logic       go;
        logic       last;
        logic [7:0] ch;
    } t_step;

    typedef struct packed {
        logic        ok;
        logic [31:0] addr;
    } t_v4_res;

    typedef struct packed {
        logic        ok;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [7:0]  zone;
    } t_v6_res;

    typedef struct packed {
        logic        valid_res;
        logic        is_v6;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [7:0]  zone;
    } t_result;

endpackage
`default_nettype wire

[src/ipta_if.sv]
// Handshake channels for characters in and parse results out.
`default_nettype none
interface ipta_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

interface ipta_out_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic        is_v6;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [7:0]  zone;

    modport source (output valid, output valid_res, output is_v6, output addr_hi,
                    output addr_lo, output zone, input ready);
    modport sink   (input valid, input valid_res, input is_v6, input addr_hi,
                    input addr_lo, input zone, output ready);
endinterface
`default_nettype wire

[src/ipta_v4.sv]
// Dotted-quad IPv4 parser: one character per step.
`default_nettype none
module ipta_v4
    import ipta_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_step   i_step,
    output t_v4_res      o_res
);

    logic       r_ok, n_ok;
    logic [7:0] r_acc, n_acc;
    logic       r_present, n_present;
    logic [1:0] r_dots, n_dots;
    logic [7:0] r_oct [3];

    logic        is_dig;
    logic [3:0]  dig;
    logic [11:0] prod;
    logic [11:0] val;
    logic        oct_we;

    always_comb begin
        is_dig    = i_step.ch inside {[CH_0:CH_9]};
        dig       = i_step.ch[3:0];
        prod      = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + {8'b0, dig};
        val       = r_present ? prod : {8'b0, dig};
        n_ok      = r_ok;
        n_acc     = r_acc;
        n_present = r_present;
        n_dots    = r_dots;
        oct_we    = 1'b0;
        if (r_ok) begin
            if (is_dig) begin
                if (val > 12'd255) begin
                    n_ok = 1'b0;
                end else begin
                    n_acc     = val[7:0];
                    n_present = 1'b1;
                end
            end else if (i_step.ch == CH_DOT) begin
                if (r_dots == 2'd3 || !r_present) begin
                    n_ok = 1'b0;
                end else begin
                    oct_we    = 1'b1;
                    n_dots    = r_dots + 2'd1;
                    n_acc     = '0;
                    n_present = 1'b0;
                end
            end else begin
                n_ok = 1'b0;
            end
        end
        o_res.ok   = n_ok && (n_dots == 2'd3) && n_present;
        o_res.addr = {r_oct[0], r_oct[1], r_oct[2], n_acc};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok      <= 1'b1;
            r_acc     <= '0;
            r_present <= 1'b0;
            r_dots    <= '0;
        end else if (i_step.go) begin
            if (i_step.last) begin
                r_ok      <= 1'b1;
                r_acc     <= '0;
                r_present <= 1'b0;
                r_dots    <= '0;
            end else begin
                r_ok      <= n_ok;
                r_acc     <= n_acc;
                r_present <= n_present;
                r_dots    <= n_dots;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.go && oct_we) begin
            r_oct[r_dots] <= r_acc;
        end
    end

endmodule
`default_nettype wire

[src/ipta_v6.sv]
// Colon-hex IPv6 parser with gap expansion and zone suffix.
`default_nettype none
module ipta_v6
    import ipta_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_step   i_step,
    output t_v6_res      o_res
);

    logic        r_ok, n_ok;
    logic [15:0] r_acc, n_acc;
    logic [2:0]  r_cnt, n_cnt;
    logic [3:0]  r_gap_pos, n_gap_pos;
    logic        r_gap_seen, n_gap_seen;
    t_pend       r_pend, n_pend;
    t_zmode      r_zmode, n_zmode;
    logic [7:0]  r_zacc, n_zacc;
    logic [15:0] r_fields [8];

    logic        is_dig;
    logic        is_hex;
    logic [3:0]  dig;
    logic        more;
    logic        f_we;
    logic [11:0] zsum;
    logic [15:0] view [8];
    logic [15:0] res [8];
    logic [3:0]  n_used;
    logic [3:0]  tail;
    logic        use_gap;
    logic [2:0]  src;

    always_comb begin
        is_dig = i_step.ch inside {[CH_0:CH_9]};
        is_hex = is_dig || (i_step.ch inside {[CH_A_LO:CH_F_LO], [CH_A_UP:CH_F_UP]});
        dig    = is_dig ? i_step.ch[3:0] : i_step.ch[3:0] + 4'd9;
        zsum   = (({4'b0, r_zacc} - 12'd1) << 3) + (({4'b0, r_zacc} - 12'd1) << 1)
                 + {8'b0, dig} + 12'd1;
        n_ok       = r_ok;
        n_acc      = r_acc;
        n_cnt      = r_cnt;
        n_gap_pos  = r_gap_pos;
        n_gap_seen = r_gap_seen;
        n_pend     = r_pend;
        n_zmode    = r_zmode;
        n_zacc     = r_zacc;
        f_we       = 1'b0;
        more       = 1'b1;
        if (r_ok) begin
            if (r_zmode != ZM_NONE) begin
                if (r_zmode == ZM_SKIP && is_dig) begin
                    n_zmode = ZM_DIGITS;
                end
                if (n_zmode == ZM_DIGITS) begin
                    if (!is_dig) begin
                        n_zmode = ZM_DONE;
                    end else if ({4'b0, r_zacc} < 12'(ZONE_SAT)) begin
                        n_zacc = (zsum > 12'(ZONE_SAT)) ? 8'(ZONE_SAT) : zsum[7:0];
                    end
                end
            end else begin
                if (r_pend == PC_ONE) begin
                    if (i_step.ch == CH_COLON) begin
                        more = 1'b0;
                        if (r_gap_seen) begin
                            n_ok = 1'b0;
                        end else begin
                            n_gap_seen = 1'b1;
                            n_gap_pos  = {1'b0, r_cnt} + {3'b0, (r_acc != '0)};
                            n_pend     = PC_GAP;
                            if (r_cnt == 3'd7) begin
                                n_ok = 1'b0;
                            end else begin
                                f_we  = 1'b1;
                                n_cnt = r_cnt + 3'd1;
                                n_acc = '0;
                            end
                        end
                    end else begin
                        n_pend = PC_NONE;
                        if (r_cnt == 3'd7) begin
                            n_ok = 1'b0;
                            more = 1'b0;
                        end else begin
                            f_we  = 1'b1;
                            n_cnt = r_cnt + 3'd1;
                            n_acc = '0;
                        end
                    end
                end else if (r_pend == PC_GAP) begin
                    if (i_step.ch == CH_COLON) begin
                        n_ok = 1'b0;
                        more = 1'b0;
                    end else begin
                        n_pend = PC_NONE;
                    end
                end
                if (more) begin
                    if (is_hex) begin
                        if (n_acc[15:12] != '0) begin
                            n_ok = 1'b0;
                        end else begin
                            n_acc = {n_acc[11:0], dig};
                        end
                    end else if (i_step.ch == CH_COLON) begin
                        n_pend = PC_ONE;
                    end else if (i_step.ch == CH_PCT) begin
                        n_zmode = ZM_SKIP;
                        n_zacc  = 8'd1;
                    end else begin
                        n_ok = 1'b0;
                    end
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            if (3'(k) == n_cnt) begin
                view[k] = n_acc;
            end else if (f_we && 3'(k) == r_cnt) begin
                view[k] = r_acc;
            end else begin
                view[k] = r_fields[k];
            end
        end
        n_used  = {1'b0, n_cnt} + 4'd1;
        tail    = n_used - n_gap_pos;
        use_gap = n_gap_seen && (n_gap_pos <= n_used);
        for (int j = 0; j < 8; j++) begin
            src = 3'(j) + n_used[2:0];
            if (!use_gap || 4'(j) < n_gap_pos) begin
                res[j] = view[j];
            end else if (4'(j) >= 4'd8 - tail) begin
                res[j] = view[src];
            end else begin
                res[j] = '0;
            end
        end
        o_res.ok   = n_ok && (n_pend != PC_ONE)
                     && (n_gap_seen ? (n_cnt != 3'd7) : (n_cnt == 3'd7));
        o_res.hi   = {res[0], res[1], res[2], res[3]};
        o_res.lo   = {res[4], res[5], res[6], res[7]};
        o_res.zone = n_zacc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok       <= 1'b1;
            r_acc      <= '0;
            r_cnt      <= '0;
            r_gap_pos  <= '0;
            r_gap_seen <= 1'b0;
            r_pend     <= PC_NONE;
            r_zmode    <= ZM_NONE;
            r_zacc     <= '0;
        end else if (i_step.go) begin
            if (i_step.last) begin
                r_ok       <= 1'b1;
                r_acc      <= '0;
                r_cnt      <= '0;
                r_gap_pos  <= '0;
                r_gap_seen <= 1'b0;
                r_pend     <= PC_NONE;
                r_zmode    <= ZM_NONE;
                r_zacc     <= '0;
            end else begin
                r_ok       <= n_ok;
                r_acc      <= n_acc;
                r_cnt      <= n_cnt;
                r_gap_pos  <= n_gap_pos;
                r_gap_seen <= n_gap_seen;
                r_pend     <= n_pend;
                r_zmode    <= n_zmode;
                r_zacc     <= n_zacc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.go && f_we) begin
            r_fields[r_cnt] <= r_acc;
        end
    end

endmodule
`default_nettype wire

[src/ip_text_address_parser_top.sv]
// Top level of the IPv4 / IPv6 text address parser.
//
// Characters enter on i_item (valid/ready, ch, last), one per item; the item
// with last set ends the string. Exactly one result leaves on o_res for each
// string: valid_res, is_v6, addr_hi, addr_lo and zone. IPv4 wins when the
// text reads as both forms; a string that is neither gives valid_res = 0.
// An accepted character is held in the input register and is folded into
// the IPv4 and IPv6 parse state at the clock edge on which it leaves that
// register; for the final character the result register loads at that same
// edge, so a result passes through the input register and then the result
// register. One character is taken every cycle unless a final character is
// stalled in the input register.
// While a result waits in the result register, further characters are still
// taken and parsed; only a further final character stalls in the input
// register until o_res.ready frees the result register.
// Reset (i_rst_n low at a clock edge) empties both registers and returns the
// parse state to the start of a string.
`default_nettype none
`include "ip_text_address_parser_top_assert.svh"
module ip_text_address_parser_top
    import ipta_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ipta_in_if.sink     i_item,
    ipta_out_if.source  o_res
);

    logic       r_in_valid;
    logic [7:0] r_ch;
    logic       r_last;
    logic       r_out_valid;
    t_result    r_res, n_res;

    logic       out_free;
    logic       p_go;
    t_step      step;
    t_v4_res    v4_res;
    t_v6_res    v6_res;

    assign out_free     = !r_out_valid || o_res.ready;
    assign p_go         = r_in_valid && (!r_last || out_free);
    assign i_item.ready = !r_in_valid || p_go;

    assign step.go   = p_go;
    assign step.last = r_last;
    assign step.ch   = r_ch;

    ipta_v4 u_v4 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .o_res   (v4_res)
    );

    ipta_v6 u_v6 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .o_res   (v6_res)
    );

    always_comb begin
        n_res = '0;
        if (v4_res.ok) begin
            n_res.valid_res = 1'b1;
            n_res.addr_lo   = {32'b0, v4_res.addr};
        end else if (v6_res.ok) begin
            n_res.valid_res = 1'b1;
            n_res.is_v6     = 1'b1;
            n_res.addr_hi   = v6_res.hi;
            n_res.addr_lo   = v6_res.lo;
            n_res.zone      = v6_res.zone;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_ch   <= i_item.ch;
            r_last <= i_item.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (p_go && r_last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_go && r_last) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.valid_res = r_res.valid_res;
    assign o_res.is_v6     = r_res.is_v6;
    assign o_res.addr_hi   = r_res.addr_hi;
    assign o_res.addr_lo   = r_res.addr_lo;
    assign o_res.zone      = r_res.zone;

    `IPTA_ASSERT_IMP(a_out_from_last, $rose(r_out_valid), $past(p_go && r_last))
    `IPTA_ASSERT_IMP(a_stall_cause, r_in_valid && !p_go, r_last && r_out_valid && !o_res.ready)
    `IPTA_ASSERT_NXT(a_stall_hold, r_in_valid && !p_go, r_in_valid && $stable(r_ch))
    `IPTA_ASSERT_IMP(a_v6_is_valid, r_out_valid && r_res.is_v6, r_res.valid_res)
    `IPTA_ASSERT_IMP(a_zone_v6_only, r_out_valid && (r_res.zone != '0), r_res.is_v6)

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Testbench of the text address parser: a directed table of strings, then random strings.
module tb_top;
    import ipta_pkg::*;

    localparam int         IDLE_LIMIT  = 2000;
    localparam int         HOLD_CYCLES = 400;
    localparam int         TAIL_CYCLES = 8;
    localparam int         RAND_CHARS  = 1700;
    localparam int         OCTET_MAX   = 255;
    localparam int         GROUP_MAX   = 'hffff;
    localparam logic [7:0] CASE_GAP    = CH_A_LO - CH_A_UP;
    localparam t_result    NO_ADDR     = '0;

    typedef struct {
        string   text;
        bit      known;
        t_result res;
    } t_case;

    t_case cases [24] = '{
        '{"0.0.0.0",          1'b1, '{1'b1, 1'b0, 64'h0, 64'h0, 8'h0}},
        '{"255.255.255.255",  1'b1, '{1'b1, 1'b0, 64'h0, 64'h0000_0000_ffff_ffff, 8'h0}},
        '{"12.34.56.78",      1'b1, '{1'b1, 1'b0, 64'h0, 64'h0000_0000_0c22_384e, 8'h0}},
        '{"256.1.1.1",        1'b1, NO_ADDR},
        '{"1.2.3",            1'b1, NO_ADDR},
        '{"1..2.3",           1'b1, NO_ADDR},
        '{"1.2.3.4.",         1'b1, NO_ADDR},
        '{"::",               1'b1, '{1'b1, 1'b1, 64'h0, 64'h0, 8'h0}},
        '{"FFFF:ffff:FfFf:fFFF:ABCD:abcd:0:1", 1'b1,
          '{1'b1, 1'b1, 64'hffff_ffff_ffff_ffff, 64'habcd_abcd_0000_0001, 8'h0}},
        '{"1:2:3:4:5:6:7:8",  1'b1,
          '{1'b1, 1'b1, 64'h0001_0002_0003_0004, 64'h0005_0006_0007_0008, 8'h0}},
        '{"1:2:3:4:5:6:7:8::", 1'b1, NO_ADDR},
        '{"1:2:3:4:5:6:7::",  1'b0, NO_ADDR},
        '{"1::2",             1'b0, NO_ADDR},
        '{":::",              1'b1, NO_ADDR},
        '{"1:",               1'b1, NO_ADDR},
        '{":1:2:3:4:5:6:7",   1'b0, NO_ADDR},
        '{"fe80::1%eth12x3",  1'b0, NO_ADDR},
        '{"::1%",             1'b0, NO_ADDR},
        '{"::1%999",          1'b0, NO_ADDR},
        '{"0:0:0:0:0:0:0:0%0", 1'b0, NO_ADDR},
        '{"a:b::c:d%7",       1'b0, NO_ADDR},
        '{"1.2.3.4%5",        1'b1, NO_ADDR},
        '{"10000::",          1'b1, NO_ADDR},
        '{"\001\377",         1'b1, NO_ADDR}
    };

    logic clk;
    logic rst_n;

    ipta_in_if  in_ch ();
    ipta_out_if res_ch ();

    ip_text_address_parser_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_item  (in_ch),
        .o_res   (res_ch)
    );

    logic        dq_ok, dq_have;
    int          dq_val, dq_dots;
    logic [7:0]  dq_oct [3];
    logic        hx_ok, hx_gap;
    int          hx_val, hx_grp, hx_gap_at;
    t_pend       hx_pend;
    logic [15:0] hx_grps [8];
    t_zmode      zn_mode;
    int          zn_val;

    t_result     expected_addrs [$];
    logic [7:0]  txt [$];
    int          mismatch_cnt = 0;
    int          idle_cnt = 0;
    int          chars_sent = 0;
    bit          burst = 1'b0;
    bit          hold_req = 1'b0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit is_dec(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic int draw_wait();
        return burst ? 0 : $urandom_range(0, 7);
    endfunction

    task automatic clear_parse();
        dq_ok   = 1'b1;
        dq_have = 1'b0;
        dq_val  = 0;
        dq_dots = 0;
        foreach (dq_oct[i]) dq_oct[i] = '0;
        hx_ok     = 1'b1;
        hx_gap    = 1'b0;
        hx_val    = 0;
        hx_grp    = 0;
        hx_gap_at = 0;
        hx_pend   = PC_NONE;
        foreach (hx_grps[i]) hx_grps[i] = '0;
        zn_mode = ZM_NONE;
        zn_val  = 0;
    endtask

    task automatic dq_char(input logic [7:0] c);
        int n;
        if (!dq_ok) return;
        if (is_dec(c)) begin
            n = dq_have ? dq_val * 10 + int'(c - CH_0) : int'(c - CH_0);
            if (n > OCTET_MAX) begin
                dq_ok = 1'b0;
            end else begin
                dq_val  = n;
                dq_have = 1'b1;
            end
        end else if (c == CH_DOT) begin
            if (dq_dots >= 3 || !dq_have) begin
                dq_ok = 1'b0;
            end else begin
                dq_oct[dq_dots] = dq_val[7:0];
                dq_dots++;
                dq_val  = 0;
                dq_have = 1'b0;
            end
        end else begin
            dq_ok = 1'b0;
        end
    endtask

    task automatic hx_split();
        if (hx_grp >= 7) begin
            hx_ok = 1'b0;
        end else begin
            hx_grps[hx_grp] = hx_val[15:0];
            hx_grp++;
            hx_val = 0;
        end
    endtask

    task automatic zn_char(input logic [7:0] c);
        int n;
        if (zn_mode == ZM_SKIP && is_dec(c)) zn_mode = ZM_DIGITS;
        if (zn_mode == ZM_DIGITS) begin
            if (!is_dec(c)) begin
                zn_mode = ZM_DONE;
            end else if (zn_val < ZONE_SAT) begin
                n = (zn_val - 1) * 10 + int'(c - CH_0) + 1;
                zn_val = (n > ZONE_SAT) ? ZONE_SAT : n;
            end
        end
    endtask

    task automatic hx_char(input logic [7:0] c);
        logic [7:0] lc;
        int         n;
        if (!hx_ok) return;
        if (zn_mode != ZM_NONE) begin
            zn_char(c);
            return;
        end
        if (hx_pend == PC_ONE) begin
            if (c == CH_COLON) begin
                if (hx_gap) begin
                    hx_ok = 1'b0;
                    return;
                end
                hx_gap    = 1'b1;
                hx_gap_at = hx_grp + ((hx_val != 0) ? 1 : 0);
                hx_pend   = PC_GAP;
                hx_split();
                return;
            end
            hx_pend = PC_NONE;
            hx_split();
            if (!hx_ok) return;
        end else if (hx_pend == PC_GAP) begin
            if (c == CH_COLON) begin
                hx_ok = 1'b0;
                return;
            end
            hx_pend = PC_NONE;
        end
        lc = (c >= CH_A_UP && c <= CH_F_UP) ? c + CASE_GAP : c;
        if (is_dec(lc) || (lc >= CH_A_LO && lc <= CH_F_LO)) begin
            n = hx_val * 16 + (is_dec(lc) ? int'(lc - CH_0) : int'(lc - CH_A_LO) + 10);
            if (n > GROUP_MAX) hx_ok = 1'b0;
            else hx_val = n;
        end else if (c == CH_COLON) begin
            hx_pend = PC_ONE;
        end else if (c == CH_PCT) begin
            zn_mode = ZM_SKIP;
            zn_val  = 1;
        end else begin
            hx_ok = 1'b0;
        end
    endtask

    task automatic parse_char(input logic [7:0] c, input logic l, output bit done,
                              output t_result r);
        logic [15:0] grp [8];
        int          n, tail;
        r    = '0;
        done = l;
        dq_char(c);
        hx_char(c);
        if (!l) return;
        if (dq_ok && (dq_dots != 3 || !dq_have)) dq_ok = 1'b0;
        if (hx_ok && hx_pend == PC_ONE) hx_ok = 1'b0;
        if (hx_ok && !hx_gap && hx_grp != 7) hx_ok = 1'b0;
        if (hx_ok && hx_gap && hx_grp > 6) hx_ok = 1'b0;
        if (dq_ok) begin
            r.valid_res = 1'b1;
            r.addr_lo   = {32'd0, dq_oct[0], dq_oct[1], dq_oct[2], dq_val[7:0]};
        end else if (hx_ok) begin
            hx_grps[hx_grp] = hx_val[15:0];
            n = hx_grp + 1;
            foreach (grp[i]) grp[i] = '0;
            if (hx_gap && hx_gap_at <= n) begin
                tail = n - hx_gap_at;
                for (int i = 0; i < hx_gap_at && i < 8; i++) grp[i] = hx_grps[i];
                for (int i = 0; i < tail; i++)
                    grp[(8 - tail + i) % 8] = hx_grps[(hx_gap_at + i) % 8];
            end else begin
                grp = hx_grps;
            end
            r.valid_res = 1'b1;
            r.is_v6     = 1'b1;
            r.addr_hi   = {grp[0], grp[1], grp[2], grp[3]};
            r.addr_lo   = {grp[4], grp[5], grp[6], grp[7]};
            r.zone      = zn_val[7:0];
        end
        clear_parse();
    endtask

    task automatic flag_error(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("%0t: %s", $time, what);
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    endtask

    function automatic logic [7:0] pick_punct();
        case ($urandom_range(0, 3))
            0:       return CH_DOT;
            1:       return CH_COLON;
            2:       return CH_PCT;
            default: return CH_0;
        endcase
    endfunction

    task automatic make_dotted();
        int parts, v;
        parts = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : 4;
        for (int i = 0; i < parts; i++) begin
            if (i > 0) txt.push_back(CH_DOT);
            if ($urandom_range(0, 7) == 0) txt.push_back(CH_0);
            v = ($urandom_range(0, 15) == 0) ? $urandom_range(256, 999) : $urandom_range(0, 255);
            put_str($sformatf("%0d", v));
        end
    endtask

    task automatic make_zone();
        txt.push_back(CH_PCT);
        repeat ($urandom_range(0, 2)) txt.push_back(CH_A_LO + 8'($urandom_range(0, 25)));
        if ($urandom_range(0, 5) != 0)
            repeat ($urandom_range(1, 4)) txt.push_back(CH_0 + 8'($urandom_range(0, 9)));
        repeat ($urandom_range(0, 2)) txt.push_back(8'($urandom_range(1, 255)));
    endtask

    task automatic make_hex();
        int         groups, gap_at, v, pick;
        bit         gapped;
        string      s;
        logic [7:0] ch;
        groups = $urandom_range(0, 8);
        gapped = ($urandom_range(0, 2) != 0) || groups == 0;
        gap_at = $urandom_range(0, groups);
        for (int i = 0; i < groups; i++) begin
            if (gapped && i == gap_at) put_str("::");
            else if (i > 0) txt.push_back(CH_COLON);
            pick = $urandom_range(0, 19);
            if (pick == 0) v = $urandom_range('h10000, 'hfffff);
            else if (pick < 6) v = $urandom_range(0, 15);
            else v = $urandom_range(0, GROUP_MAX);
            if ($urandom_range(0, 3) == 0) txt.push_back(CH_0);
            s = $sformatf("%0h", v);
            for (int k = 0; k < s.len(); k++) begin
                ch = s[k];
                if (ch >= CH_A_LO && $urandom_range(0, 1) == 1) ch = ch - CASE_GAP;
                txt.push_back(ch);
            end
        end
        if (gapped && gap_at == groups) put_str("::");
        if ($urandom_range(0, 3) == 0) make_zone();
    endtask

    task automatic make_noise(input int max_len);
        repeat ($urandom_range(1, max_len)) txt.push_back(8'($urandom_range(1, 255)));
    endtask

    task automatic mutate();
        int at;
        at = $urandom_range(0, txt.size() - 1);
        case ($urandom_range(0, 2))
            0:       txt.delete(at);
            1:       txt.insert(at, pick_punct());
            default: txt[at] = 8'($urandom_range(1, 255));
        endcase
        if (txt.size() == 0) txt.push_back(CH_COLON);
    endtask

    task automatic send_char(input logic [7:0] c, input logic l, input bit known,
                             input t_result fixed);
        int      gap;
        bit      done;
        t_result r;
        gap = draw_wait();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.ch    <= c;
        in_ch.last  <= l;
        do @(posedge clk); while (!in_ch.ready);
        parse_char(c, l, done, r);
        if (done) expected_addrs.push_back(known ? fixed : r);
        chars_sent++;
    endtask

    task automatic send_txt(input bit known, input t_result fixed);
        for (int i = 0; i < txt.size(); i++)
            send_char(txt[i], i == txt.size() - 1, known, fixed);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_addrs.size() != 0);
    endtask

    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= IDLE_LIMIT) begin
            $display("** ip_text_address_parser_top: FAILED **");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    initial begin : result_sink
        int      stall;
        t_result got, want;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            stall = draw_wait();
            if (hold_req) begin
                hold_req = 1'b0;
                stall    = HOLD_CYCLES;
            end
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
            got = {res_ch.valid_res, res_ch.is_v6, res_ch.addr_hi, res_ch.addr_lo,
                   res_ch.zone};
            if (expected_addrs.size() == 0) begin
                flag_error($sformatf("result with none expected: %b/%b %h %h %h",
                                     got.valid_res, got.is_v6, got.addr_hi, got.addr_lo,
                                     got.zone));
            end else begin
                want = expected_addrs.pop_front();
                if (got.valid_res !== want.valid_res || got.is_v6 !== want.is_v6 ||
                    got.addr_hi !== want.addr_hi || got.addr_lo !== want.addr_lo ||
                    got.zone !== want.zone)
                    flag_error($sformatf("exp %b/%b %h %h %h got %b/%b %h %h %h",
                                         want.valid_res, want.is_v6, want.addr_hi,
                                         want.addr_lo, want.zone, got.valid_res,
                                         got.is_v6, got.addr_hi, got.addr_lo, got.zone));
            end
        end
    end

    initial begin : stimulus
        bit pressed;
        pressed     = 1'b0;
        rst_n       <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.ch    <= CH_0;
        in_ch.last  <= 1'b0;
        clear_parse();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        foreach (cases[i]) begin
            txt.delete();
            put_str(cases[i].text);
            send_txt(cases[i].known, cases[i].res);
        end
        drain();
        while (chars_sent < RAND_CHARS) begin
            if ($urandom_range(0, 9) == 0) burst = !burst;
            if (!pressed && chars_sent > RAND_CHARS / 3) begin
                // hold off the result side while short strings pile up
                pressed  = 1'b1;
                hold_req = 1'b1;
                repeat (24) begin
                    txt.delete();
                    make_noise(3);
                    send_txt(1'b0, NO_ADDR);
                end
                drain();
            end
            txt.delete();
            case ($urandom_range(0, 9))
                0, 1, 2, 3:    make_dotted();
                4, 5, 6, 7, 8: make_hex();
                default:       make_noise(8);
            endcase
            if ($urandom_range(0, 7) == 0) mutate();
            send_txt(1'b0, NO_ADDR);
            if ($urandom_range(0, 39) == 0) drain();
        end
        in_ch.valid <= 1'b0;
        while (expected_addrs.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0) begin
            $display("** ip_text_address_parser_top: PASSED **");
        end else begin
            $display("** ip_text_address_parser_top: FAILED **");
        end
        $finish;
    end

endmodule
